/* design/blifo_pkg.sv */
// Package for the bounded LIFO stack: command codes, field widths,
// register map and the read-request struct shared by the control and output stages.
// No dependencies.
`timescale 1ns / 1ps

package blifo_pkg;

  // Payload field widths
  localparam int CMD_W  = 3;
  localparam int DATA_W = 32;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DUMP_UP   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP_DOWN = 3'd4;

  // Configuration register map (word index taken from paddr[2])
  localparam int              PADDR_W      = 3;
  localparam int              PDATA_W      = 32;
  localparam int              CAP_W        = 7;
  localparam logic [CAP_W-1:0] CAP_RESET   = 7'd64;
  localparam logic            REG_CAPACITY = 1'b0;

  // Parameter defaults
  localparam int DEPTH_DEF     = 64;
  localparam int WORD_BITS_DEF = 32;

  // Read request from the control stage to the output stage
  typedef struct packed {
    logic vld;
    logic last;
  } rd_req_t;

endpackage

/* design/blifo_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
// Read data holds while no read is requested. No dependencies.
`timescale 1ns / 1ps

module blifo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/blifo_cfg.sv */
// APB-style configuration register block holding the stack capacity.
// Depends on blifo_pkg for the register map and widths.
`timescale 1ns / 1ps

module blifo_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [blifo_pkg::PADDR_W-1:0] paddr,
  input  logic [blifo_pkg::PDATA_W-1:0] pwdata,
  output logic [blifo_pkg::PDATA_W-1:0] prdata,
  output logic                          pready,
  output logic [blifo_pkg::CAP_W-1:0]   cap
);

  import blifo_pkg::*;

  logic [CAP_W-1:0] cap_r;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

  // Capture the capacity on a completed write transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (wr_en) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  // Read back
  assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(cap_r) : '0;
  assign cap    = cap_r;

endmodule

/* design/blifo_ctrl.sv */
// Stack control: entry count, command decode, dump sequencer and RAM access.
// Depends on blifo_pkg for command codes and the read-request struct.
`timescale 1ns / 1ps

module blifo_ctrl #(
  parameter int DEPTH     = blifo_pkg::DEPTH_DEF,
  parameter int WORD_BITS = blifo_pkg::WORD_BITS_DEF,
  parameter int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [blifo_pkg::CMD_W-1:0]         in_command,
  input  logic signed [blifo_pkg::DATA_W-1:0] in_value,
  input  logic [blifo_pkg::CAP_W-1:0]         cap,
  input  logic                                issue_ok,
  output blifo_pkg::rd_req_t                  rd_req,
  output logic                                ram_we,
  output logic [AW-1:0]                       ram_waddr,
  output logic [WORD_BITS-1:0]                ram_wdata,
  output logic [AW-1:0]                       ram_raddr
);

  import blifo_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic          state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic          up_r, up_nxt;

  logic          in_acc;
  logic          nonempty;
  logic          push_ok;
  logic [AW-1:0] top_idx;
  logic          dump_last;

  assign in_stall  = (state_r == ST_DUMP) || !issue_ok;
  assign in_acc    = in_valid && !in_stall;
  assign nonempty  = (count_r != '0);
  assign push_ok   = (8'(count_r) < 8'(cap)) && (8'(count_r) < 8'(DEPTH));
  assign top_idx   = AW'(count_r - 1'b1);
  assign dump_last = up_r ? (ptr_r == top_idx) : (ptr_r == '0);

  // Push data sign-extends or truncates to the stored word width
  assign ram_wdata = WORD_BITS'(in_value);
  assign ram_waddr = AW'(count_r);

  // Decode commands and step the dump walk
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    ptr_nxt     = ptr_r;
    up_nxt      = up_r;
    ram_we      = 1'b0;
    ram_raddr   = top_idx;
    rd_req.vld  = 1'b0;
    rd_req.last = 1'b0;
    if (state_r == ST_DUMP) begin
      ram_raddr = ptr_r;
      if (issue_ok) begin
        rd_req.vld  = 1'b1;
        rd_req.last = dump_last;
        if (dump_last) begin
          state_nxt = ST_IDLE;
        end else if (up_r) begin
          ptr_nxt = ptr_r + 1'b1;
        end else begin
          ptr_nxt = ptr_r - 1'b1;
        end
      end
    end else if (in_acc) begin
      unique case (in_command)
        CMD_PUSH: begin
          if (push_ok) begin
            ram_we    = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_POP: begin
          if (nonempty) begin
            count_nxt = count_r - 1'b1;
          end
        end
        CMD_PEEK: begin
          if (nonempty) begin
            rd_req.vld  = 1'b1;
            rd_req.last = 1'b1;
          end
        end
        CMD_DUMP_UP: begin
          if (nonempty) begin
            state_nxt = ST_DUMP;
            up_nxt    = 1'b1;
            ptr_nxt   = '0;
          end
        end
        CMD_DUMP_DOWN: begin
          if (nonempty) begin
            state_nxt = ST_DUMP;
            up_nxt    = 1'b0;
            ptr_nxt   = top_idx;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Walk pointer and direction
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    up_r  <= up_nxt;
  end

endmodule

/* design/blifo_outq.sv */
// Output stage: tracks the RAM read stage and holds the result register.
// Depends on blifo_pkg for the read-request struct and the word width.
`timescale 1ns / 1ps

module blifo_outq #(
  parameter int WORD_BITS = blifo_pkg::WORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  blifo_pkg::rd_req_t                  rd_req,
  input  logic [WORD_BITS-1:0]                rd_data,
  output logic                                issue_ok,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [blifo_pkg::DATA_W-1:0] out_word,
  output logic                                out_last
);

  import blifo_pkg::*;

  logic                     rd_valid_r, rd_valid_nxt;
  logic                     rd_last_r;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_word_r;
  logic                     out_last_r;

  logic                     out_take;
  logic                     rd_move;

  assign out_take = out_valid_r && !out_stall;
  assign rd_move  = rd_valid_r && (!out_valid_r || !out_stall);
  assign issue_ok = !rd_valid_r || rd_move;

  // Advance the read stage into the result register
  always_comb begin
    rd_valid_nxt = rd_valid_r;
    if (rd_req.vld) begin
      rd_valid_nxt = 1'b1;
    end else if (rd_move) begin
      rd_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (rd_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: last flag follows its read, word is zero-extended or truncated to the output width
  always_ff @(posedge clk) begin
    if (rd_req.vld) begin
      rd_last_r <= rd_req.last;
    end
    if (rd_move) begin
      out_word_r <= signed'(DATA_W'(rd_data));
      out_last_r <= rd_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_last  = out_last_r;

endmodule

/* design/bounded_lifo_stack.sv */
// Bounded LIFO stack: top level joining configuration, control, entry RAM and output stage.
// One command is accepted per cycle while no dump is running and the output side is not backed up.
// Peek: the result passes through the RAM read register, then the result register, before it is valid.
// Dump of n words: input stalls while the walk issues one RAM read per cycle when the output is not backed up.
// Reset: entry count zero, capacity 64; the entry RAM is not cleared.
// Depends on blifo_pkg, blifo_cfg, blifo_ctrl, blifo_ram and blifo_outq.
`timescale 1ns / 1ps

module bounded_lifo_stack #(
  parameter int DEPTH     = blifo_pkg::DEPTH_DEF,
  parameter int WORD_BITS = blifo_pkg::WORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [blifo_pkg::CMD_W-1:0]         in_command,
  input  logic signed [blifo_pkg::DATA_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [blifo_pkg::DATA_W-1:0] out_word,
  output logic                                out_last,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [blifo_pkg::PADDR_W-1:0]       paddr,
  input  logic [blifo_pkg::PDATA_W-1:0]       pwdata,
  output logic [blifo_pkg::PDATA_W-1:0]       prdata,
  output logic                                pready
);

  import blifo_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CAP_W-1:0]     cap;
  logic                 issue_ok;
  rd_req_t              rd_req;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // Capacity register
  blifo_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap     (cap)
  );

  // Command decode, count and dump walk
  blifo_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .AW        (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_value   (in_value),
    .cap        (cap),
    .issue_ok   (issue_ok),
    .rd_req     (rd_req),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr)
  );

  // Entry store
  blifo_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_req.vld),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Read stage and result register
  blifo_outq #(
    .WORD_BITS (WORD_BITS)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_req    (rd_req),
    .rd_data   (ram_rdata),
    .issue_ok  (issue_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .out_last  (out_last)
  );

endmodule
